/* sv/hvg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hemisphere vertex generator package
// Shared types, constants and helper functions of the vertex pipeline.
// ----------------------------------------------------------------------------
package hvg_pkg;

  localparam int unsigned CW = 34;
  localparam int unsigned AtanDepth = 24;
  localparam logic signed [CW-1:0] KINV_Q30 = 34'sd652032874;

  localparam logic [31:0] ATAN_TURN [AtanDepth] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam logic [2:0] REG_SEGMENT_COUNT = 3'd0;
  localparam logic [2:0] REG_RING_COUNT    = 3'd1;
  localparam logic [2:0] REG_DOME_RADIUS   = 3'd2;
  localparam logic [2:0] REG_CENTER_X      = 3'd3;
  localparam logic [2:0] REG_CENTER_Y      = 3'd4;
  localparam logic [2:0] REG_CENTER_Z      = 3'd5;
  localparam logic [2:0] REG_FADE_GAIN     = 3'd6;

  typedef struct packed {
    logic        oor;
    logic        rfull;
    logic        sfull;
    logic        quad;
    logic [15:0] vn;
  } meta_t;

  typedef struct packed {
    logic [7:0]  rem;
    logic [31:0] quo;
  } div_lane_t;

  // Eight restoring division steps on the fraction of rem / d.
  function automatic div_lane_t div_step8(div_lane_t a, logic [7:0] d);
    logic [8:0] r2;
    div_lane_t  o;
    o = a;
    for (int i = 0; i < 8; i++) begin
      r2 = {o.rem, 1'b0};
      o.quo = {o.quo[30:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
        o.rem = 8'(r2 - {1'b0, d});
        o.quo[0] = 1'b1;
      end else begin
        o.rem = r2[7:0];
      end
    end
    return o;
  endfunction

  // Round half up, then shift right by 30.
  function automatic logic signed [31:0] rnd30(logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + (64'sd1 <<< 29)) >>> 30;
    return t[31:0];
  endfunction

endpackage

/* sv/hvg_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hemisphere vertex generator CORDIC
// Pipelined rotation CORDIC on a turn-fraction phase, one iteration per stage.
// ----------------------------------------------------------------------------
module hvg_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  logic               clk_i,
  input  logic [STAGES-1:0]  en_i,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import hvg_pkg::*;

  logic signed [CW-1:0] x_q [STAGES];
  logic signed [CW-1:0] y_q [STAGES];
  logic signed [31:0]   z_q [STAGES];
  logic [1:0]           quad_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic signed [CW-1:0] x_in, y_in;
    logic signed [31:0]   z_in;
    logic [1:0]           quad_in;

    if (s == 0) begin : g_first
      assign x_in    = KINV_Q30;
      assign y_in    = '0;
      assign z_in    = $signed({2'b00, phase_i[29:0]});
      assign quad_in = phase_i[31:30];
    end else begin : g_next
      assign x_in    = x_q[s-1];
      assign y_in    = y_q[s-1];
      assign z_in    = z_q[s-1];
      assign quad_in = quad_q[s-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        quad_q[s] <= quad_in;
        if (!z_in[31]) begin
          x_q[s] <= x_in - (y_in >>> s);
          y_q[s] <= y_in + (x_in >>> s);
          z_q[s] <= z_in - $signed(ATAN_TURN[s]);
        end else begin
          x_q[s] <= x_in + (y_in >>> s);
          y_q[s] <= y_in - (x_in >>> s);
          z_q[s] <= z_in + $signed(ATAN_TURN[s]);
        end
      end
    end
  end

  logic signed [CW-1:0] xl, yl, c_full, s_full;
  assign xl = x_q[STAGES-1];
  assign yl = y_q[STAGES-1];

  always_comb begin
    unique case (quad_q[STAGES-1])
      2'd0: begin c_full = xl;  s_full = yl;  end
      2'd1: begin c_full = -yl; s_full = xl;  end
      2'd2: begin c_full = -xl; s_full = -yl; end
      default: begin c_full = yl; s_full = -xl; end
    endcase
  end

  assign cos_o = c_full[31:0];
  assign sin_o = s_full[31:0];

endmodule

/* sv/hemisphere_vertex_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hemisphere vertex generator
// Turns ring and segment numbers into sky dome vertices: position, normal,
// texture coordinates, vertex number and quad index base.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         ring_number, segment_number
// m_axis    out        position, normal, texture, vertex number, flags
// APB       in/out     seven configuration registers at byte address 4*i
//
// One transaction enters per cycle while the output is not stalled; the pipeline
// is the input register, the four division stages, the CORDIC stages and three
// multiply/add stages.
// Every stage has its own valid bit and loads when it is empty or drains, so
// a stall at the output fills bubbles without losing data.
// Reset clears valid bits and restores register defaults.
// ----------------------------------------------------------------------------
module hemisphere_vertex_generator #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned MAX_COUNT     = 255
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ring_number[7:0], segment_number[15:8]
  input  logic [15:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], norm_x[111:96], norm_y[127:112],
  // norm_z[143:128], tex_u[160:144], tex_v[177:161], vertex_number[193:178],
  // quad_valid[194], index_base[213:195], out_of_range[214], zero[215]
  output logic [215:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import hvg_pkg::*;

  localparam int unsigned NS = CORDIC_STAGES + 8;
  localparam int unsigned C0 = 5;
  localparam int unsigned M1 = CORDIC_STAGES + 5;
  localparam int unsigned M2 = CORDIC_STAGES + 6;
  localparam int unsigned FS = CORDIC_STAGES + 7;

  // Configuration registers.
  logic [7:0]         seg_cnt_q, ring_cnt_q;
  logic [30:0]        radius_q;
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [15:0]        fade_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_cnt_q  <= 8'd16;
      ring_cnt_q <= 8'd8;
      radius_q   <= 31'd65536;
      cx_q       <= '0;
      cy_q       <= '0;
      cz_q       <= '0;
      fade_q     <= 16'd256;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        REG_SEGMENT_COUNT: seg_cnt_q  <= pwdata[7:0];
        REG_RING_COUNT:    ring_cnt_q <= pwdata[7:0];
        REG_DOME_RADIUS:   radius_q   <= pwdata[30:0];
        REG_CENTER_X:      cx_q       <= pwdata;
        REG_CENTER_Y:      cy_q       <= pwdata;
        REG_CENTER_Z:      cz_q       <= pwdata;
        REG_FADE_GAIN:     fade_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SEGMENT_COUNT: prdata = {24'd0, seg_cnt_q};
      REG_RING_COUNT:    prdata = {24'd0, ring_cnt_q};
      REG_DOME_RADIUS:   prdata = {1'b0, radius_q};
      REG_CENTER_X:      prdata = cx_q;
      REG_CENTER_Y:      prdata = cy_q;
      REG_CENTER_Z:      prdata = cz_q;
      REG_FADE_GAIN:     prdata = {16'd0, fade_q};
      default:           prdata = '0;
    endcase
  end

  logic [7:0] rc, sc;
  assign rc = (ring_cnt_q > 8'(MAX_COUNT)) ? 8'(MAX_COUNT) : ring_cnt_q;
  assign sc = (seg_cnt_q > 8'(MAX_COUNT)) ? 8'(MAX_COUNT) : seg_cnt_q;

  // Stage control.
  logic [NS-1:0] vld_q;
  logic [NS:0]   ld;

  always_comb begin
    ld[NS] = m_axis_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = ld[0];
  assign m_axis_tvalid = vld_q[NS-1];

  // Metadata travels with every stage.
  logic [7:0] ring_in, seg_in;
  meta_t      meta_d;
  meta_t      meta_q [NS];

  assign ring_in = s_axis_tdata[7:0];
  assign seg_in  = s_axis_tdata[15:8];

  always_comb begin
    meta_d.oor   = (rc == 8'd0) || (sc == 8'd0) || (ring_in > rc) || (seg_in > sc);
    meta_d.rfull = (ring_in == rc);
    meta_d.sfull = (seg_in == sc);
    meta_d.quad  = (ring_in < rc);
    meta_d.vn    = 16'({8'd0, ring_in} * ({8'd0, sc} + 16'd1) + {8'd0, seg_in});
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      meta_q[0] <= meta_d;
    end
    for (int k = 1; k < NS; k++) begin
      if (ld[k]) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // Phase division: fraction bits of ring/rc and seg/sc.
  div_lane_t divr_q [5];
  div_lane_t divs_q [5];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      divr_q[0] <= '{rem: ring_in, quo: '0};
      divs_q[0] <= '{rem: seg_in, quo: '0};
    end
    for (int k = 1; k < 5; k++) begin
      if (ld[k]) begin
        divr_q[k] <= div_step8(divr_q[k-1], rc);
        divs_q[k] <= div_step8(divs_q[k-1], sc);
      end
    end
  end

  logic [31:0] ph_ring, ph_half, ph_seg;
  assign ph_ring = meta_q[4].rfull ? 32'h4000_0000 : {2'b00, divr_q[4].quo[31:2]};
  assign ph_half = meta_q[4].rfull ? 32'h2000_0000 : {3'b000, divr_q[4].quo[31:3]};
  assign ph_seg  = meta_q[4].sfull ? 32'h0000_0000 : divs_q[4].quo;

  logic signed [31:0] cr, sr, ch_unused, sh, cs, ss;

  hvg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_ring (
    .clk_i   (clk_i),
    .en_i    (ld[C0 +: CORDIC_STAGES]),
    .phase_i (ph_ring),
    .cos_o   (cr),
    .sin_o   (sr)
  );

  hvg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_half (
    .clk_i   (clk_i),
    .en_i    (ld[C0 +: CORDIC_STAGES]),
    .phase_i (ph_half),
    .cos_o   (ch_unused),
    .sin_o   (sh)
  );

  hvg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_seg (
    .clk_i   (clk_i),
    .en_i    (ld[C0 +: CORDIC_STAGES]),
    .phase_i (ph_seg),
    .cos_o   (cs),
    .sin_o   (ss)
  );

  // First multiply stage: direction and scaled texture terms.
  logic signed [31:0] dx_q, dy_q, dz_q, qu_q, qv_q, ch_q;

  always_ff @(posedge clk_i) begin
    if (ld[M1]) begin
      dx_q <= rnd30(64'(sr) * 64'(cs));
      dy_q <= rnd30(64'(sr) * 64'(ss));
      dz_q <= cr;
      qu_q <= rnd30(64'(sh) * 64'(cs));
      qv_q <= rnd30(64'(sh) * 64'(ss));
      ch_q <= ch_unused;
    end
  end

  // Second multiply stage: radius scaling, normals, fade scaling.
  logic signed [31:0] px_q, py_q, pz_q, tu_q, tv_q;
  logic signed [15:0] nx_q, ny_q, nz_q;
  logic signed [63:0] rad_s, fade_s;

  assign rad_s  = $signed({33'd0, radius_q});
  assign fade_s = $signed({48'd0, fade_q});

  function automatic logic signed [15:0] norm16(logic signed [31:0] d);
    logic signed [31:0] t;
    t = (d + 32'sd32768) >>> 16;
    if (t > 32'sd16384) begin
      return 16'sd16384;
    end else if (t < -32'sd16384) begin
      return -16'sd16384;
    end
    return t[15:0];
  endfunction

  function automatic logic signed [31:0] fade22(logic signed [31:0] q,
                                                logic signed [63:0] f);
    logic signed [63:0] t;
    t = ((64'(q) * f * 64'sd2) + (64'sd1 <<< 21)) >>> 22;
    return t[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (ld[M2]) begin
      px_q <= rnd30(rad_s * 64'(dx_q));
      py_q <= rnd30(rad_s * 64'(dy_q));
      pz_q <= rnd30(rad_s * 64'(dz_q));
      nx_q <= norm16(dx_q);
      ny_q <= norm16(dy_q);
      nz_q <= norm16(dz_q);
      tu_q <= fade22(qu_q, fade_s);
      tv_q <= fade22(qv_q, fade_s);
    end
  end

  // Output stage: origin offset, texture clamp, flags.
  function automatic logic [16:0] tex17(logic signed [31:0] t);
    logic signed [31:0] v;
    v = t + 32'sd32768;
    if (v < 32'sd0) begin
      return 17'd0;
    end else if (v > 32'sd65536) begin
      return 17'd65536;
    end
    return v[16:0];
  endfunction

  logic [215:0] out_d, out_q;
  meta_t        mf;
  assign mf = meta_q[M2];

  always_comb begin
    out_d = '0;
    if (mf.oor) begin
      out_d[214] = 1'b1;
    end else begin
      out_d[31:0]    = cx_q + px_q;
      out_d[63:32]   = cy_q + py_q;
      out_d[95:64]   = cz_q + pz_q;
      out_d[111:96]  = nx_q;
      out_d[127:112] = ny_q;
      out_d[143:128] = nz_q;
      out_d[160:144] = tex17(tu_q);
      out_d[177:161] = tex17(tv_q);
      out_d[193:178] = mf.vn;
      out_d[194]     = mf.quad;
      out_d[213:195] = mf.quad ? 19'({3'd0, mf.vn} * 19'd6) : 19'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[FS]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = out_q;

  // Checks.
  logic unused_ok;
  assign unused_ok = ^ch_q;

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NS-1] |-> s_axis_tready)
    else $error("input not ready with empty output stage");

  a_oor_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[214]) |-> (m_axis_tdata[213:0] == '0))
    else $error("rejected request carries data");

  a_index_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[194])
      |-> (m_axis_tdata[213:195] == 19'({3'd0, m_axis_tdata[193:178]} * 19'd6)))
    else $error("index base mismatch");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[160:144] <= 17'd65536)
                   && (m_axis_tdata[177:161] <= 17'd65536))
    else $error("texture coordinate out of range");

endmodule
